@@ sv/sdt_pkg.sv @@
// Shared constants, codes and controller/datapath types of the stick direction tracker.
package sdt_pkg;

  // Sizes of the calibration accumulators and the serial divider.
  localparam int unsigned SumW     = 24;
  localparam int unsigned CntW     = 8;
  localparam int unsigned DivSteps = 24;
  localparam int unsigned DivCntW  = 5;

  // A calibration run counts at most this many samples.
  localparam logic [CntW-1:0] MaxCalSamples = 8'd255;

  // Direction codes.
  localparam logic [2:0] DirCenter = 3'd0;
  localparam logic [2:0] DirUp     = 3'd1;
  localparam logic [2:0] DirDown   = 3'd2;
  localparam logic [2:0] DirLeft   = 3'd3;
  localparam logic [2:0] DirRight  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CfgCenterLow  = 3'd0;
  localparam logic [2:0] CfgCenterHigh = 3'd1;
  localparam logic [2:0] CfgSpread     = 3'd2;
  localparam logic [2:0] CfgRelease    = 3'd3;
  localparam logic [2:0] CfgEngage     = 3'd4;
  localparam logic [2:0] CfgSwapXy     = 3'd5;
  localparam logic [2:0] CfgFlipX      = 3'd6;
  localparam logic [2:0] CfgFlipY      = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input transfer
    logic exec;      // apply the captured sample to the state
    logic div_load;  // start both center divisions
    logic div_step;  // one restoring division step
    logic finish;    // write centers, qualify, emit the result
  } sdt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cal;  // captured item is the final calibration sample
    logic out_free;  // the output register can take a result this cycle
  } sdt_status_t;

endpackage

@@ sv/stick_direction_tracker_top.sv @@
// Top level of the stick direction tracker: controller and datapath.
// The block takes one sample at a time. A stick sample or a calibration sample that is not the
// last of its run is captured, then executed into the output register; the last calibration
// sample then runs 24 serial restoring division steps that form both centers at once.
// The next sample is taken as soon as the current one is finished, while its result may still
// wait in the output register. A result leaves the output register no earlier than the cycle
// after it is formed. Configuration writes take effect at once and are meant for idle periods.
module stick_direction_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_sample, [31:16] y_sample
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [2:0] direction, [3] calibrated, [4] calibration_done
);
  import sdt_pkg::*;

  sdt_cmd_t    cmd;
  sdt_status_t status;

  sdt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  sdt_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

@@ sv/sdt_div.sv @@
// Restoring serial divider: one quotient bit per step for a 24-bit magnitude by an 8-bit count.
module sdt_div (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [sdt_pkg::SumW-1:0]   dividend_i,
  input  logic [sdt_pkg::CntW-1:0]   divisor_i,
  output logic [sdt_pkg::SumW-1:0]   quotient_o
);
  import sdt_pkg::*;

  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW:0]   trial;
  logic [CntW:0]   diff;

  // Shift the next dividend bit into the remainder and try a subtraction.
  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    diff  = trial - {1'b0, divisor_i};
    quo_d = quo_q;
    rem_d = rem_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      if (!diff[CntW]) begin
        rem_d = diff[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;

endmodule

@@ sv/sdt_ctrl.sv @@
// Sequencing state machine: accept, execute, run the center divisions, finish.
module sdt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  sdt_pkg::sdt_status_t  status_i,
  output sdt_pkg::sdt_cmd_t     cmd_o
);
  import sdt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StExec  = 3'd1;
  localparam logic [2:0] StDload = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        if (status_i.last_cal) begin
          cmd_o.exec = 1'b1;
          state_d    = StDload;
        end else if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      StDload: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = DivCntW'(DivSteps);
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ sv/sdt_datapath.sv @@
// Configuration, calibration accumulators, direction state and the output register.
module sdt_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic [31:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,
  input  sdt_pkg::sdt_cmd_t     cmd_i,
  output sdt_pkg::sdt_status_t  status_o
);
  import sdt_pkg::*;

  // Configuration registers.
  logic signed [15:0] lo_lim_q, hi_lim_q;
  logic [15:0]        spread_q;
  logic [14:0]        rel_q, eng_q;
  logic               swap_q, flip_x_q, flip_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_lim_q <= 16'sh8000;
      hi_lim_q <= 16'sh7fff;
      spread_q <= 16'hffff;
      rel_q    <= 15'd4096;
      eng_q    <= 15'd8192;
      swap_q   <= 1'b0;
      flip_x_q <= 1'b0;
      flip_y_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCenterLow:  lo_lim_q <= cfg_wdata_i;
        CfgCenterHigh: hi_lim_q <= cfg_wdata_i;
        CfgSpread:     spread_q <= cfg_wdata_i;
        CfgRelease:    rel_q    <= cfg_wdata_i[14:0];
        CfgEngage:     eng_q    <= cfg_wdata_i[14:0];
        CfgSwapXy:     swap_q   <= cfg_wdata_i[0];
        CfgFlipX:      flip_x_q <= cfg_wdata_i[0];
        CfgFlipY:      flip_y_q <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // Captured input item.
  logic               act_q, last_q;
  logic signed [15:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= s_axis_tuser;
      last_q <= s_axis_tlast;
      x_q    <= s_axis_tdata[15:0];
      y_q    <= s_axis_tdata[31:16];
    end
  end

  // Tracking and calibration state.
  logic                   track_q, track_d;
  logic                   armed_q, armed_d;
  logic                   incal_q, incal_d;
  logic [2:0]             held_q, held_d;
  logic signed [15:0]     cx_q, cx_d, cy_q, cy_d;
  logic signed [SumW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [15:0]     minx_q, minx_d, maxx_q, maxx_d;
  logic signed [15:0]     miny_q, miny_d, maxy_q, maxy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  // Divider operands and results.
  logic [SumW-1:0]        mag_x, mag_y, quo_x, quo_y;
  logic [CntW-1:0]        divisor;
  logic [SumW-1:0]        cen_x24, cen_y24;
  logic signed [15:0]     cen_x, cen_y;
  logic [16:0]            spr_x, spr_y;
  logic                   ok_x, ok_y;

  assign mag_x   = sx_q[SumW-1] ? SumW'(-sx_q) : SumW'(sx_q);
  assign mag_y   = sy_q[SumW-1] ? SumW'(-sy_q) : SumW'(sy_q);
  assign divisor = (cnt_q == '0) ? CntW'(1) : cnt_q;

  sdt_div u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_x),
    .divisor_i  (divisor),
    .quotient_o (quo_x)
  );

  sdt_div u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_y),
    .divisor_i  (divisor),
    .quotient_o (quo_y)
  );

  // Signed centers and plausibility of the finished run.
  assign cen_x24 = sx_q[SumW-1] ? (~quo_x + 1'b1) : quo_x;
  assign cen_y24 = sy_q[SumW-1] ? (~quo_y + 1'b1) : quo_y;
  assign cen_x   = cen_x24[15:0];
  assign cen_y   = cen_y24[15:0];
  assign spr_x   = 17'(signed'({maxx_q[15], maxx_q}) - signed'({minx_q[15], minx_q}));
  assign spr_y   = 17'(signed'({maxy_q[15], maxy_q}) - signed'({miny_q[15], miny_q}));
  assign ok_x    = (cen_x >= lo_lim_q) && (cen_x <= hi_lim_q) && (spr_x <= {1'b0, spread_q});
  assign ok_y    = (cen_y >= lo_lim_q) && (cen_y <= hi_lim_q) && (spr_y <= {1'b0, spread_q});

  // Sample update: calibration accumulation or stick qualification.
  logic                   first;
  logic signed [SumW-1:0] bsx, bsy;
  logic [CntW-1:0]        bcnt;
  logic signed [15:0]     bminx, bmaxx, bminy, bmaxy;
  logic signed [16:0]     dx0, dy0, dx1, dy1, dx, dy, rel_s;
  logic [16:0]            absx, absy;
  logic [14:0]            ax, ay;
  logic                   keep;

  always_comb begin
    track_d = track_q;
    armed_d = armed_q;
    incal_d = incal_q;
    held_d  = held_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    minx_d  = minx_q;
    maxx_d  = maxx_q;
    miny_d  = miny_q;
    maxy_d  = maxy_q;
    cnt_d   = cnt_q;

    first = !incal_q;
    bsx   = first ? '0 : sx_q;
    bsy   = first ? '0 : sy_q;
    bcnt  = first ? '0 : cnt_q;
    bminx = first ? x_q : minx_q;
    bmaxx = first ? x_q : maxx_q;
    bminy = first ? y_q : miny_q;
    bmaxy = first ? y_q : maxy_q;

    rel_s = signed'({2'b00, rel_q});
    dx0   = signed'({x_q[15], x_q}) - signed'({cx_q[15], cx_q});
    dy0   = signed'({y_q[15], y_q}) - signed'({cy_q[15], cy_q});
    dx1   = swap_q ? dy0 : dx0;
    dy1   = swap_q ? dx0 : dy0;
    dx    = flip_x_q ? -dx1 : dx1;
    dy    = flip_y_q ? -dy1 : dy1;
    absx  = dx[16] ? 17'(-dx) : 17'(dx);
    absy  = dy[16] ? 17'(-dy) : 17'(dy);
    ax    = absx[16:15] != 2'b00 ? 15'h7fff : absx[14:0];
    ay    = absy[16:15] != 2'b00 ? 15'h7fff : absy[14:0];

    // A held direction stays while its own axis is still past the release band.
    case (held_q)
      DirRight: keep = dx > rel_s;
      DirLeft:  keep = -dx > rel_s;
      DirDown:  keep = dy > rel_s;
      DirUp:    keep = -dy > rel_s;
      default:  keep = 1'b0;
    endcase

    if (cmd_i.exec && !act_q) begin
      // Calibration sample.
      incal_d = !last_q;
      sx_d    = bsx;
      sy_d    = bsy;
      cnt_d   = bcnt;
      minx_d  = bminx;
      maxx_d  = bmaxx;
      miny_d  = bminy;
      maxy_d  = bmaxy;
      if (first) begin
        track_d = 1'b0;
        armed_d = 1'b1;
        held_d  = DirCenter;
      end
      if (bcnt < MaxCalSamples) begin
        sx_d   = bsx + SumW'(x_q);
        sy_d   = bsy + SumW'(y_q);
        minx_d = (x_q < bminx) ? x_q : bminx;
        maxx_d = (x_q > bmaxx) ? x_q : bmaxx;
        miny_d = (y_q < bminy) ? y_q : bminy;
        maxy_d = (y_q > bmaxy) ? y_q : bmaxy;
        cnt_d  = bcnt + 1'b1;
      end
    end else if (cmd_i.exec) begin
      // Stick sample.
      incal_d = 1'b0;
      if (!track_q) begin
        held_d = DirCenter;
      end else if (!keep) begin
        held_d = DirCenter;
        if ((ax < rel_q) && (ay < rel_q)) begin
          armed_d = 1'b1;
        end
        if (armed_d) begin
          if ((ax >= ay) && (ax > eng_q)) begin
            held_d  = (dx > 17'sd0) ? DirRight : DirLeft;
            armed_d = 1'b0;
          end else if ((ay > ax) && (ay > eng_q)) begin
            held_d  = (dy > 17'sd0) ? DirDown : DirUp;
            armed_d = 1'b0;
          end
        end
      end
    end

    if (cmd_i.finish) begin
      cx_d    = cen_x;
      cy_d    = cen_y;
      track_d = ok_x && ok_y;
      incal_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= 1'b0;
      armed_q <= 1'b1;
      incal_q <= 1'b0;
      held_q  <= DirCenter;
      cx_q    <= '0;
      cy_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      minx_q  <= '0;
      maxx_q  <= '0;
      miny_q  <= '0;
      maxy_q  <= '0;
      cnt_q   <= '0;
    end else begin
      track_q <= track_d;
      armed_q <= armed_d;
      incal_q <= incal_d;
      held_q  <= held_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      minx_q  <= minx_d;
      maxx_q  <= maxx_d;
      miny_q  <= miny_d;
      maxy_q  <= maxy_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register: holds one result until its transfer completes.
  logic       out_valid_q, out_valid_d;
  logic       out_wr;
  logic [2:0] out_dir_q;
  logic       out_cal_q, out_done_q;

  assign out_wr = (cmd_i.exec && !(!act_q && last_q)) || cmd_i.finish;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_wr) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_dir_q  <= held_d;
      out_cal_q  <= track_d;
      out_done_q <= cmd_i.finish;
    end
  end

  assign m_axis_tvalid     = out_valid_q;
  assign m_axis_tdata      = {3'b000, out_done_q, out_cal_q, out_dir_q};
  assign status_o.last_cal = !act_q && last_q;
  assign status_o.out_free = !out_valid_q || m_axis_tready;

endmodule

@@ sv/sdt_checker.sv @@
// Port-level checks of the stick direction tracker and their binding to the top level.
module sdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A result waiting for its transfer keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Samples are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  // A completed calibration always reports the center direction.
  a_done_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("calibration result with a direction");

  // A direction other than center needs successful calibration.
  a_dir_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[3])
    else $error("direction reported while not calibrated");

endmodule

bind stick_direction_tracker_top sdt_checker u_sdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
